[rtl/core/bsu_pkg.sv]
// Shared types and codes for the blocking semaphore unit.
`timescale 1ns / 1ps

package bsu_pkg;

  // Field widths fixed by the item format
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 3;
  localparam int COUNT_W = 8;

  // Operation codes carried in the command field
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_SIGNAL = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Requests from the sequencer to the thread table
  typedef struct packed {
    logic search_start;
    logic scan_step;
    logic block_set;
  } thr_ctrl_t;

  // Search status from the thread table
  typedef struct packed {
    logic hit;
    logic exhausted;
  } thr_status_t;

endpackage

[rtl/core/bsu_count_mem.sv]
// Semaphore count memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module bsu_count_mem #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [bsu_pkg::COUNT_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [bsu_pkg::COUNT_W-1:0]   wr_data
);

  logic [bsu_pkg::COUNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid;
  logic [bsu_pkg::COUNT_W-1:0] rd_q;
  logic                        rd_valid;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written entries; reset leaves every count at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // An entry never written reads as zero
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

[rtl/core/bsu_thread_table.sv]
// Per-thread blocked flags and wait semaphores, with a round-robin waiter scan.
`timescale 1ns / 1ps

module bsu_thread_table #(
  parameter int NUM_THREADS = 8,
  parameter int THR_W       = 3,
  parameter int LEFT_W      = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bsu_pkg::thr_ctrl_t          ctrl,
  input  logic [bsu_pkg::IDX_W-1:0]   sem,
  input  logic [THR_W-1:0]            run,
  output bsu_pkg::thr_status_t        status,
  output logic [THR_W-1:0]            ptr
);

  logic [NUM_THREADS-1:0]      blocked;
  logic [bsu_pkg::IDX_W-1:0]   wait_sem [NUM_THREADS];
  logic [NUM_THREADS-1:0]      match;
  logic [LEFT_W-1:0]           left;
  logic [THR_W-1:0]            run_next;
  logic [THR_W-1:0]            ptr_next;

  // Wrap-around successors of the running thread and of the scan pointer
  assign run_next = (run == THR_W'(NUM_THREADS - 1)) ? '0 : run + 1'b1;
  assign ptr_next = (ptr == THR_W'(NUM_THREADS - 1)) ? '0 : ptr + 1'b1;

  // Blocked flags: set on a blocking wait, clear on wake
  always_ff @(posedge clk) begin
    if (rst) begin
      blocked <= '0;
    end else if (ctrl.block_set) begin
      blocked[run] <= 1'b1;
    end else if (ctrl.scan_step && match[ptr]) begin
      blocked[ptr] <= 1'b0;
    end
  end

  // Wait semaphore per thread
  always_ff @(posedge clk) begin
    if (ctrl.block_set) begin
      wait_sem[run] <= sem;
    end else if (ctrl.scan_step && match[ptr]) begin
      wait_sem[ptr] <= '0;
    end
  end

  // Snapshot which threads wait on the signalled semaphore
  always_ff @(posedge clk) begin
    if (ctrl.search_start) begin
      for (int t = 0; t < NUM_THREADS; t++) begin
        match[t] <= blocked[t] && (wait_sem[t] == sem);
      end
    end
  end

  // Scan pointer and remaining step count
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      ptr  <= '0;
    end else if (ctrl.search_start) begin
      ptr  <= run_next;
      left <= LEFT_W'(NUM_THREADS);
    end else if (ctrl.scan_step && !match[ptr]) begin
      ptr  <= ptr_next;
      left <= left - 1'b1;
    end
  end

  assign status.hit       = (left != '0) && match[ptr];
  assign status.exhausted = (left == '0);

endmodule

[rtl/core/blocking_semaphore_unit_top.sv]
// Top level of the blocking semaphore unit: stream ports and operation sequencer.
`timescale 1ns / 1ps

// Counting semaphores with blocked-thread tracking. Each input item is one
// call (init, wait or signal) on one semaphore by the running thread; each
// item yields exactly one result item. Items are handled one at a time: an
// init, a wait, or a signal that leaves the count positive goes from acceptance
// to result through count memory read, update and write-back, and result load.
// A signal that leaves the count at zero or below scans the threads round robin,
// one per cycle, starting after the running thread, until it finds a waiter or
// has passed over every thread, before the result load.
// The next item is accepted as soon as the result sits in the output
// register, even while that result waits to be taken. Counts saturate at
// -128 and 127 with error_flag set; a signal finding no waiter, an unused
// command, or an out-of-range semaphore or thread also sets error_flag.
module blocking_semaphore_unit_top #(
  parameter int NUM_THREADS    = 8,
  parameter int NUM_SEMAPHORES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] command, [4:2] sem_index, [7:5] running_thread, [15:8] init_value
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] caller_blocked, [1] woken_valid, [4:2] woken_thread, [12:5] new_count,
  // [13] error_flag, [15:14] zero
  output logic [15:0] m_tdata
);

  localparam int SEM_AW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int THR_W  = $clog2(NUM_THREADS);
  localparam int LEFT_W = $clog2(NUM_THREADS + 1);
  localparam logic [6:0] SEM_LIMIT = 7'(NUM_SEMAPHORES);
  localparam logic [5:0] THR_LIMIT = 6'(NUM_THREADS);
  localparam logic signed [7:0] COUNT_MAX = 8'sd127;
  localparam logic signed [7:0] COUNT_MIN = -8'sd128;

  bsu_pkg::state_t               state;
  bsu_pkg::state_t               state_next;
  bsu_pkg::cmd_t                 cmd;
  logic [bsu_pkg::IDX_W-1:0]     sem;
  logic [bsu_pkg::IDX_W-1:0]     run;
  logic signed [7:0]             init_value;
  logic                          accept;
  logic                          sem_ok;
  logic                          run_ok;
  logic                          op_ok;

  logic signed [7:0]             cur_count;
  logic signed [7:0]             count_next;
  logic                          err_next;
  logic                          block_next;
  logic                          search_next;

  logic                          res_blocked;
  logic                          res_woken;
  logic [2:0]                    res_thread;
  logic signed [7:0]             res_count;
  logic                          res_err;

  logic                          mem_wr_en;
  bsu_pkg::thr_ctrl_t            thr_ctrl;
  bsu_pkg::thr_status_t          thr_status;
  logic [THR_W-1:0]              scan_ptr;
  logic                          out_load;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == bsu_pkg::ST_IDLE);
  assign out_load = (state == bsu_pkg::ST_DONE) && (!m_tvalid || m_tready);

  // Hold the accepted item's fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= bsu_pkg::cmd_t'(s_tdata[1:0]);
      sem        <= s_tdata[4:2];
      run        <= s_tdata[7:5];
      init_value <= s_tdata[15:8];
    end
  end

  assign sem_ok = {4'b0, sem} < SEM_LIMIT;
  assign run_ok = {3'b0, run} < THR_LIMIT;
  assign op_ok  = sem_ok && run_ok && (cmd != bsu_pkg::CMD_UNUSED);

  bsu_count_mem #(
    .DEPTH  (NUM_SEMAPHORES),
    .ADDR_W (SEM_AW)
  ) u_count_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && ({4'b0, s_tdata[4:2]} < SEM_LIMIT)),
    .rd_addr (SEM_AW'(s_tdata[4:2])),
    .rd_data (cur_count),
    .wr_en   (mem_wr_en),
    .wr_addr (SEM_AW'(sem)),
    .wr_data (count_next)
  );

  bsu_thread_table #(
    .NUM_THREADS (NUM_THREADS),
    .THR_W       (THR_W),
    .LEFT_W      (LEFT_W)
  ) u_thread_table (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (thr_ctrl),
    .sem    (sem),
    .run    (THR_W'(run)),
    .status (thr_status),
    .ptr    (scan_ptr)
  );

  // Update the count read from memory
  always_comb begin
    count_next  = cur_count;
    err_next    = 1'b0;
    block_next  = 1'b0;
    search_next = 1'b0;
    if (!sem_ok) begin
      count_next = '0;
      err_next   = 1'b1;
    end else if (!op_ok) begin
      err_next = 1'b1;
    end else begin
      case (cmd)
        bsu_pkg::CMD_INIT: begin
          count_next = init_value;
        end
        bsu_pkg::CMD_WAIT: begin
          if (cur_count == COUNT_MIN) begin
            err_next = 1'b1;
          end else begin
            count_next = cur_count - 8'sd1;
          end
          block_next = count_next[7];
        end
        bsu_pkg::CMD_SIGNAL: begin
          if (cur_count == COUNT_MAX) begin
            err_next = 1'b1;
          end else begin
            count_next = cur_count + 8'sd1;
          end
          search_next = count_next[7] || (count_next == '0);
        end
        default: begin
          err_next = 1'b1;
        end
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bsu_pkg::ST_IDLE: begin
        if (accept) state_next = bsu_pkg::ST_EXEC;
      end
      bsu_pkg::ST_EXEC: begin
        state_next = search_next ? bsu_pkg::ST_SCAN : bsu_pkg::ST_DONE;
      end
      bsu_pkg::ST_SCAN: begin
        if (thr_status.hit || thr_status.exhausted) state_next = bsu_pkg::ST_DONE;
      end
      bsu_pkg::ST_DONE: begin
        if (out_load) state_next = bsu_pkg::ST_IDLE;
      end
      default: state_next = bsu_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mem_wr_en             = 1'b0;
    thr_ctrl.search_start = 1'b0;
    thr_ctrl.scan_step    = 1'b0;
    thr_ctrl.block_set    = 1'b0;
    unique case (state)
      bsu_pkg::ST_EXEC: begin
        mem_wr_en             = op_ok;
        thr_ctrl.block_set    = block_next;
        thr_ctrl.search_start = search_next;
      end
      bsu_pkg::ST_SCAN: begin
        thr_ctrl.scan_step = !thr_status.exhausted;
      end
      default: begin
      end
    endcase
  end

  // Collect the result fields
  always_ff @(posedge clk) begin
    if (state == bsu_pkg::ST_EXEC) begin
      res_count   <= count_next;
      res_err     <= err_next;
      res_blocked <= block_next;
      res_woken   <= 1'b0;
      res_thread  <= '0;
    end else if (state == bsu_pkg::ST_SCAN) begin
      if (thr_status.exhausted) begin
        res_err <= 1'b1;
      end else if (thr_status.hit) begin
        res_woken  <= 1'b1;
        res_thread <= 3'(scan_ptr);
      end
    end
  end

  // Output register: load the finished item, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, res_err, res_count, res_thread, res_woken, res_blocked};
    end
  end

endmodule

[tb/blocking_semaphore_unit_top_tb.sv]
// Self-checking testbench for the blocking semaphore unit top level.
`timescale 1ns / 1ps

module blocking_semaphore_unit_top_tb;

  localparam int THREADS    = 8;
  localparam int SEMAPHORES = 8;
  localparam int HALF_CYCLE = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_CALLS = 1950;
  localparam int STEADY_FIRST = 700;
  localparam int STEADY_LAST  = 1100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PERCENT = 27;
  localparam int IDX_W        = bsu_pkg::IDX_W;
  localparam int COUNT_W      = bsu_pkg::COUNT_W;

  // One result item as the block reports it
  typedef struct packed {
    logic                      caller_blocked;
    logic                      woken_valid;
    logic [IDX_W-1:0]          woken_thread;
    logic signed [COUNT_W-1:0] new_count;
    logic                      error_flag;
  } call_outcome_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // [1:0] command, [4:2] sem_index, [7:5] running_thread, [15:8] init_value
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // [0] caller_blocked, [1] woken_valid, [4:2] woken_thread, [12:5] new_count,
  // [13] error_flag, [15:14] zero
  logic [15:0] m_tdata;

  // Shadow copy of the semaphore and thread tables
  logic signed [COUNT_W-1:0] shadow_count [SEMAPHORES];
  logic                      shadow_blocked [THREADS];
  logic [IDX_W-1:0]          shadow_wait_sem [THREADS];

  call_outcome_t pending_outcomes [$];
  int            mismatches;
  int            cycle_count;
  logic          steady_flow;

  blocking_semaphore_unit_top #(
    .NUM_THREADS    (THREADS),
    .NUM_SEMAPHORES (SEMAPHORES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Free-running clock
  always begin
    clk = 1'b1;
    #HALF_CYCLE;
    clk = 1'b0;
    #HALF_CYCLE;
  end

  // Abort a run that reaches the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result side at random, except during the steady stretch
  always @(negedge clk) begin
    m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Apply one semaphore call to the shadow tables and return its outcome
  function automatic call_outcome_t apply_call(input bsu_pkg::cmd_t cmd,
                                               input logic [IDX_W-1:0] sem,
                                               input logic [IDX_W-1:0] thr,
                                               input logic signed [COUNT_W-1:0] init_value);
    call_outcome_t             outcome;
    logic signed [COUNT_W-1:0] count_next;
    int                        candidate;
    outcome    = '0;
    count_next = shadow_count[sem];
    case (cmd)
      bsu_pkg::CMD_INIT: begin
        count_next = init_value;
      end
      bsu_pkg::CMD_WAIT: begin
        if (count_next == -128) outcome.error_flag = 1'b1;
        else count_next = count_next - 8'sd1;
        if (count_next < 0) begin
          shadow_blocked[thr]  = 1'b1;
          shadow_wait_sem[thr] = sem;
          outcome.caller_blocked = 1'b1;
        end
      end
      bsu_pkg::CMD_SIGNAL: begin
        if (count_next == 127) outcome.error_flag = 1'b1;
        else count_next = count_next + 8'sd1;
        if (count_next <= 0) begin
          // Search round robin from the thread after the caller, ending with the caller
          for (int k = 1; k <= THREADS; k++) begin
            candidate = (int'(thr) + k) % THREADS;
            if (!outcome.woken_valid && shadow_blocked[candidate] &&
                shadow_wait_sem[candidate] == sem) begin
              shadow_blocked[candidate]  = 1'b0;
              shadow_wait_sem[candidate] = '0;
              outcome.woken_valid  = 1'b1;
              outcome.woken_thread = candidate[IDX_W-1:0];
            end
          end
          if (!outcome.woken_valid) outcome.error_flag = 1'b1;
        end
      end
      default: begin
        outcome.error_flag = 1'b1;
      end
    endcase
    shadow_count[sem] = count_next;
    outcome.new_count = count_next;
    return outcome;
  endfunction

  // Offer one call item and record its outcome once it is taken
  task automatic issue_call(input bsu_pkg::cmd_t cmd, input logic [IDX_W-1:0] sem,
                            input logic [IDX_W-1:0] thr,
                            input logic signed [COUNT_W-1:0] init_value);
    int gap;
    gap = 0;
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {init_value, thr, sem, cmd};
    do @(posedge clk); while (!s_tready);
    pending_outcomes.push_back(apply_call(cmd, sem, thr, init_value));
    @(negedge clk);
  endtask

  // Compare each result item with the oldest outcome waiting
  always @(posedge clk) begin
    call_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result item: m_tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tdata[0] !== want.caller_blocked) begin
          $error("caller_blocked: expected %0d, actual %0d", want.caller_blocked, m_tdata[0]);
          mismatches++;
        end
        if (m_tdata[1] !== want.woken_valid) begin
          $error("woken_valid: expected %0d, actual %0d", want.woken_valid, m_tdata[1]);
          mismatches++;
        end
        if (m_tdata[4:2] !== want.woken_thread) begin
          $error("woken_thread: expected %0d, actual %0d", want.woken_thread, m_tdata[4:2]);
          mismatches++;
        end
        if (m_tdata[12:5] !== want.new_count) begin
          $error("new_count: expected %0d, actual %0d", want.new_count,
                 $signed(m_tdata[12:5]));
          mismatches++;
        end
        if (m_tdata[13] !== want.error_flag) begin
          $error("error_flag: expected %0d, actual %0d", want.error_flag, m_tdata[13]);
          mismatches++;
        end
        if (m_tdata[15:14] !== 2'b00) begin
          $error("padding: expected 0, actual %0d", m_tdata[15:14]);
          mismatches++;
        end
      end
    end
  end

  // Saturation at both ends of the count range
  task automatic test_saturation();
    issue_call(bsu_pkg::CMD_INIT,   3'd0, 3'd0, 8'sd127);
    issue_call(bsu_pkg::CMD_SIGNAL, 3'd0, 3'd0, 8'sd0);
    issue_call(bsu_pkg::CMD_WAIT,   3'd0, 3'd1, 8'sd0);
    issue_call(bsu_pkg::CMD_INIT,   3'd0, 3'd7, -8'sd128);
    issue_call(bsu_pkg::CMD_WAIT,   3'd0, 3'd1, 8'sd0);
    issue_call(bsu_pkg::CMD_SIGNAL, 3'd0, 3'd1, 8'sd0);
  endtask

  // Wait by a thread already blocked, then a signal that finds nobody
  task automatic test_rebind_and_no_waiter();
    issue_call(bsu_pkg::CMD_INIT,   3'd1, 3'd0, 8'sh55);
    issue_call(bsu_pkg::CMD_INIT,   3'd1, 3'd0, -8'sd128);
    issue_call(bsu_pkg::CMD_WAIT,   3'd1, 3'd2, 8'sd0);
    issue_call(bsu_pkg::CMD_WAIT,   3'd3, 3'd2, 8'sd0);
    issue_call(bsu_pkg::CMD_SIGNAL, 3'd1, 3'd0, 8'sd0);
    issue_call(bsu_pkg::CMD_SIGNAL, 3'd3, 3'd7, 8'sd0);
  endtask

  // Round robin wake order, including the caller itself as last candidate
  task automatic test_wake_order();
    issue_call(bsu_pkg::CMD_INIT,   3'd5, 3'd0, -8'sh56);
    issue_call(bsu_pkg::CMD_INIT,   3'd5, 3'd0, 8'sd0);
    issue_call(bsu_pkg::CMD_WAIT,   3'd5, 3'd3, 8'sd0);
    issue_call(bsu_pkg::CMD_WAIT,   3'd5, 3'd6, 8'sd0);
    issue_call(bsu_pkg::CMD_WAIT,   3'd5, 3'd1, 8'sd0);
    issue_call(bsu_pkg::CMD_SIGNAL, 3'd5, 3'd3, 8'sd0);
    issue_call(bsu_pkg::CMD_SIGNAL, 3'd5, 3'd6, 8'sd0);
    issue_call(bsu_pkg::CMD_SIGNAL, 3'd5, 3'd0, 8'sd0);
    issue_call(bsu_pkg::CMD_WAIT,   3'd6, 3'd4, 8'sd0);
    issue_call(bsu_pkg::CMD_SIGNAL, 3'd6, 3'd4, 8'sd0);
  endtask

  // Unused command leaves the state alone
  task automatic test_unused_command();
    issue_call(bsu_pkg::CMD_UNUSED, 3'd4, 3'd5, 8'sd3);
    issue_call(bsu_pkg::CMD_UNUSED, 3'd0, 3'd2, -8'sd1);
  endtask

  // Random calls concentrated around zero counts so that threads block and wake
  task automatic test_random_traffic();
    bsu_pkg::cmd_t             cmd;
    logic signed [COUNT_W-1:0] init_value;
    logic [IDX_W-1:0]          sem_pick;
    logic [IDX_W-1:0]          thr_pick;
    int                        pick;
    for (int n = 0; n < RANDOM_CALLS; n++) begin
      steady_flow = (n >= STEADY_FIRST && n < STEADY_LAST);
      pick = $urandom_range(99);
      if (pick < 15) cmd = bsu_pkg::CMD_INIT;
      else if (pick < 55) cmd = bsu_pkg::CMD_WAIT;
      else if (pick < 95) cmd = bsu_pkg::CMD_SIGNAL;
      else cmd = bsu_pkg::CMD_UNUSED;
      if ($urandom_range(9) == 0) init_value = COUNT_W'($urandom_range(255));
      else init_value = COUNT_W'($urandom_range(6) - 3);
      sem_pick = IDX_W'($urandom_range(SEMAPHORES - 1));
      thr_pick = IDX_W'($urandom_range(THREADS - 1));
      issue_call(cmd, sem_pick, thr_pick, init_value);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    steady_flow = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    for (int i = 0; i < SEMAPHORES; i++) shadow_count[i] = '0;
    for (int i = 0; i < THREADS; i++) begin
      shadow_blocked[i]  = 1'b0;
      shadow_wait_sem[i] = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    test_saturation();
    test_rebind_and_no_waiter();
    test_wake_order();
    test_unused_command();
    test_random_traffic();

    // Drain outstanding results, then allow for a full scan
    s_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (THREADS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bsu_pkg.sv
rtl/core/bsu_count_mem.sv
rtl/core/bsu_thread_table.sv
rtl/core/blocking_semaphore_unit_top.sv
tb/blocking_semaphore_unit_top_tb.sv
